[rtl/core/coo_pkg.sv]
package coo_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 11;
    localparam int COL_W    = 10;
    localparam int DATA_W   = 64;
    localparam int RIDX_W   = 13;
    localparam int STS_W    = 2;
    localparam int UNF_W    = 14;
    localparam int ROWCNT_W = 11;
    localparam int DECL_W   = 13;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int COL_LIMIT = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_FINISH    = 2'd1,
        OP_READ_PTR  = 2'd2,
        OP_READ_ELEM = 2'd3
    } op_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_MISMATCH  = 2'd2,
        STS_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_SYMMETRIC = 2'd0,
        REG_ROWS      = 2'd1,
        REG_COLUMNS   = 2'd2,
        REG_DECLARED  = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_A,
        ST_CNT_AW,
        ST_CNT_B,
        ST_CNT_BW,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SCT_RD,
        ST_SCT_A,
        ST_SCT_AW,
        ST_SCT_B,
        ST_SCT_BW,
        ST_RD_WAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic                symmetric_mode;
        logic [ROWCNT_W-1:0] row_count;
        logic [ROWCNT_W-1:0] column_count;
        logic [DECL_W-1:0]   declared_nonzeros;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  entry_row;
        logic [IDX_W-1:0]  entry_column;
        logic [DATA_W-1:0] entry_value;
        logic [RIDX_W-1:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [DATA_W-1:0] data_word;
        logic [COL_W-1:0]  column_out;
        logic [UNF_W-1:0]  unfolded_count;
    } out_item_t;

endpackage

[rtl/core/coo_if.sv]
interface coo_in_if;
    import coo_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [IDX_W-1:0]    entry_row;
    logic [IDX_W-1:0]    entry_column;
    logic [DATA_W-1:0]   entry_value;
    logic [RIDX_W-1:0]   read_index;

    modport source (output valid, operation, entry_row, entry_column, entry_value,
                    read_index, input ready);
    modport sink (input valid, operation, entry_row, entry_column, entry_value,
                  read_index, output ready);
endinterface

interface coo_out_if;
    import coo_pkg::*;
    logic                valid;
    logic                ready;
    logic [STS_W-1:0]    status;
    logic [DATA_W-1:0]   data_word;
    logic [COL_W-1:0]    column_out;
    logic [UNF_W-1:0]    unfolded_count;

    modport source (output valid, status, data_word, column_out, unfolded_count,
                    input ready);
    modport sink (input valid, status, data_word, column_out, unfolded_count,
                  output ready);
endinterface

[rtl/core/coo_cfg.sv]
module coo_cfg
    import coo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign sel    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_SYMMETRIC: cfg_next.symmetric_mode    = pwdata[0];
                REG_ROWS:      cfg_next.row_count         = pwdata[ROWCNT_W-1:0];
                REG_COLUMNS:   cfg_next.column_count      = pwdata[ROWCNT_W-1:0];
                REG_DECLARED:  cfg_next.declared_nonzeros = pwdata[DECL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_SYMMETRIC: prdata = APB_DW'(cfg_reg.symmetric_mode);
            REG_ROWS:      prdata = APB_DW'(cfg_reg.row_count);
            REG_COLUMNS:   prdata = APB_DW'(cfg_reg.column_count);
            REG_DECLARED:  prdata = APB_DW'(cfg_reg.declared_nonzeros);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.symmetric_mode    <= 1'b0;
            cfg_reg.row_count         <= ROWCNT_W'(1024);
            cfg_reg.column_count      <= ROWCNT_W'(1024);
            cfg_reg.declared_nonzeros <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/coo_engine.sv]
module coo_engine
    import coo_pkg::*;
#(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096,
    parameter int VALUE_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    localparam int CSR_DEPTH = 2 * MAX_ENTRIES;
    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RIW = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(CSR_DEPTH);
    localparam int TW  = $clog2(CSR_DEPTH + 1);

    logic [IDX_W-1:0]       ent_row_mem [MAX_ENTRIES];
    logic [COL_W-1:0]       ent_col_mem [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] ent_val_mem [MAX_ENTRIES];
    logic [TW-1:0]          row_mem     [MAX_ROWS];
    logic [TW-1:0]          ptr_mem     [MAX_ROWS + 1];
    logic [COL_W-1:0]       csr_col_mem [CSR_DEPTH];
    logic [VALUE_WIDTH-1:0] csr_val_mem [CSR_DEPTH];

    logic [IDX_W-1:0]       ent_row_q;
    logic [COL_W-1:0]       ent_col_q;
    logic [VALUE_WIDTH-1:0] ent_val_q;
    logic [TW-1:0]          row_q;
    logic [TW-1:0]          ptr_q;
    logic [COL_W-1:0]       csr_col_q;
    logic [VALUE_WIDTH-1:0] csr_val_q;

    logic                   ent_we;
    logic [AW-1:0]          ent_waddr;
    logic [AW-1:0]          ent_raddr;
    logic [IDX_W-1:0]       ent_wrow;
    logic [COL_W-1:0]       ent_wcol;
    logic                   row_we;
    logic [RAW-1:0]         row_waddr;
    logic [RAW-1:0]         row_raddr;
    logic [TW-1:0]          row_wdata;
    logic                   ptr_we;
    logic [RIW-1:0]         ptr_waddr;
    logic [RIW-1:0]         ptr_raddr;
    logic [TW-1:0]          ptr_wdata;
    logic                   csr_we;
    logic [CW-1:0]          csr_waddr;
    logic [CW-1:0]          csr_raddr;
    logic [COL_W-1:0]       csr_wcol;

    state_t                 state_reg, state_next;
    logic [EW-1:0]          idx_reg, idx_next;
    logic [RIW-1:0]         ri_reg, ri_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [TW-1:0]          acc_reg, acc_next;
    logic [EW-1:0]          entries_reg, entries_next;
    logic [TW-1:0]          unf_reg, unf_next;
    logic                   built_reg, built_next;
    status_t                sts_reg, sts_next;
    logic [DATA_W-1:0]      data_reg, data_next;
    logic [COL_W-1:0]       col_reg, col_next;
    op_t                    op_reg, op_next;

    logic [TW-1:0]          add_a, add_b, add_s;
    logic [31:0]            rows_use, cols_use;
    logic [IDX_W-1:0]       ld_r, ld_c;
    logic                   ld_mirror, mirror_q;
    op_t                    in_op;

    assign add_s    = add_a + add_b;
    assign rows_use = (32'(cfg.row_count) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS)
                                                          : 32'(cfg.row_count);
    assign cols_use = (32'(cfg.column_count) > 32'(COL_LIMIT)) ? 32'(COL_LIMIT)
                                                              : 32'(cfg.column_count);
    assign ld_r      = item.entry_row - IDX_W'(1);
    assign ld_c      = item.entry_column - IDX_W'(1);
    assign ld_mirror = cfg.symmetric_mode && (ld_r != ld_c);
    assign mirror_q  = cfg.symmetric_mode && (ent_row_q != IDX_W'(ent_col_q));
    assign in_op     = op_t'(item.operation);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res.status         = sts_reg;
    assign res.data_word      = data_reg;
    assign res.column_out     = col_reg;
    assign res.unfolded_count = UNF_W'(unf_reg);

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_row_mem[ent_waddr] <= ent_wrow;
            ent_col_mem[ent_waddr] <= ent_wcol;
            ent_val_mem[ent_waddr] <= item.entry_value[VALUE_WIDTH-1:0];
        end
        ent_row_q <= ent_row_mem[ent_raddr];
        ent_col_q <= ent_col_mem[ent_raddr];
        ent_val_q <= ent_val_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_q <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        ptr_q <= ptr_mem[ptr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (csr_we)
        begin
            csr_col_mem[csr_waddr] <= csr_wcol;
            csr_val_mem[csr_waddr] <= ent_val_q;
        end
        csr_col_q <= csr_col_mem[csr_raddr];
        csr_val_q <= csr_val_mem[csr_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ri_next      = ri_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        entries_next = entries_reg;
        unf_next     = unf_reg;
        built_next   = built_reg;
        sts_next     = sts_reg;
        data_next    = data_reg;
        col_next     = col_reg;
        op_next      = op_reg;
        add_a        = row_q;
        add_b        = TW'(1);
        ent_we       = 1'b0;
        ent_waddr    = entries_reg[AW-1:0];
        ent_raddr    = idx_reg[AW-1:0];
        ent_wrow     = ld_r;
        ent_wcol     = ld_c[COL_W-1:0];
        row_we       = 1'b0;
        row_waddr    = RAW'(ent_row_q);
        row_raddr    = RAW'(ent_row_q);
        row_wdata    = add_s;
        ptr_we       = 1'b0;
        ptr_waddr    = '0;
        ptr_raddr    = RIW'(item.read_index);
        ptr_wdata    = '0;
        csr_we       = 1'b0;
        csr_waddr    = CW'(row_q);
        csr_raddr    = CW'(item.read_index);
        csr_wcol     = ent_col_q;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = in_op;
                    data_next = '0;
                    col_next  = '0;
                    sts_next  = STS_OK;
                    state_next = ST_RESP;
                    case (in_op)
                        OP_LOAD:
                        begin
                            if (item.entry_row == '0 || item.entry_column == '0
                                || 32'(ld_r) >= rows_use || 32'(ld_c) >= cols_use
                                || (ld_mirror && 32'(ld_c) >= rows_use))
                            begin
                                sts_next = STS_BAD_INDEX;
                            end
                            else if (32'(entries_reg) >= 32'(MAX_ENTRIES))
                            begin
                                sts_next = STS_OVERFLOW;
                            end
                            else
                            begin
                                ent_we       = 1'b1;
                                built_next   = 1'b0;
                                entries_next = entries_reg + EW'(1);
                                unf_next     = unf_reg + (ld_mirror ? TW'(2) : TW'(1));
                            end
                        end
                        OP_FINISH:
                        begin
                            built_next = 1'b0;
                            idx_next   = '0;
                            state_next = ST_CHK_RD;
                        end
                        OP_READ_PTR:
                        begin
                            if (!built_reg)
                            begin
                                sts_next = STS_OVERFLOW;
                            end
                            else if (32'(item.read_index) > rows_use)
                            begin
                                sts_next = STS_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        OP_READ_ELEM:
                        begin
                            if (!built_reg)
                            begin
                                sts_next = STS_OVERFLOW;
                            end
                            else if (32'(item.read_index) >= 32'(unf_reg)
                                     || 32'(item.read_index) >= 32'(CSR_DEPTH))
                            begin
                                sts_next = STS_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                if (op_reg == OP_READ_PTR)
                begin
                    data_next = DATA_W'(ptr_q);
                end
                else
                begin
                    data_next = DATA_W'(csr_val_q);
                    col_next  = csr_col_q;
                end
                state_next = ST_RESP;
            end
            ST_CHK_RD:
            begin
                if (idx_reg == entries_reg)
                begin
                    ri_next    = '0;
                    state_next = ST_CLR;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (32'(ent_row_q) >= 32'(MAX_ROWS)
                    || (mirror_q && 32'(ent_col_q) >= 32'(MAX_ROWS)))
                begin
                    sts_next   = STS_BAD_INDEX;
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + EW'(1);
                    state_next = ST_CHK_RD;
                end
            end
            ST_CLR:
            begin
                row_we    = 1'b1;
                row_waddr = RAW'(ri_reg);
                row_wdata = '0;
                ptr_we    = 1'b1;
                ri_next   = ri_reg + RIW'(1);
                if (32'(ri_reg) == 32'(MAX_ROWS - 1))
                begin
                    idx_next   = '0;
                    total_next = '0;
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_RD:
            begin
                if (idx_reg == entries_reg)
                begin
                    unf_next = total_reg;
                    if (!cfg.symmetric_mode
                        && 32'(total_reg) != 32'(cfg.declared_nonzeros))
                    begin
                        sts_next   = STS_MISMATCH;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ri_next    = '0;
                        acc_next   = '0;
                        state_next = ST_PFX_RD;
                    end
                end
                else
                begin
                    state_next = ST_CNT_A;
                end
            end
            ST_CNT_A:
            begin
                state_next = ST_CNT_AW;
            end
            ST_CNT_AW:
            begin
                row_we     = 1'b1;
                total_next = total_reg + TW'(1);
                if (mirror_q)
                begin
                    state_next = ST_CNT_B;
                end
                else
                begin
                    idx_next   = idx_reg + EW'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_B:
            begin
                row_raddr  = RAW'(ent_col_q);
                state_next = ST_CNT_BW;
            end
            ST_CNT_BW:
            begin
                row_we     = 1'b1;
                row_waddr  = RAW'(ent_col_q);
                total_next = total_reg + TW'(1);
                idx_next   = idx_reg + EW'(1);
                state_next = ST_CNT_RD;
            end
            ST_PFX_RD:
            begin
                row_raddr  = RAW'(ri_reg);
                state_next = ST_PFX_WR;
            end
            ST_PFX_WR:
            begin
                add_a     = acc_reg;
                add_b     = row_q;
                ptr_we    = 1'b1;
                ptr_waddr = ri_reg + RIW'(1);
                ptr_wdata = add_s;
                row_we    = 1'b1;
                row_waddr = RAW'(ri_reg);
                row_wdata = acc_reg;
                acc_next  = add_s;
                ri_next   = ri_reg + RIW'(1);
                if (32'(ri_reg) == 32'(MAX_ROWS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_SCT_RD;
                end
                else
                begin
                    state_next = ST_PFX_RD;
                end
            end
            ST_SCT_RD:
            begin
                if (idx_reg == entries_reg)
                begin
                    built_next = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SCT_A;
                end
            end
            ST_SCT_A:
            begin
                state_next = ST_SCT_AW;
            end
            ST_SCT_AW:
            begin
                csr_we = 1'b1;
                row_we = 1'b1;
                if (mirror_q)
                begin
                    state_next = ST_SCT_B;
                end
                else
                begin
                    idx_next   = idx_reg + EW'(1);
                    state_next = ST_SCT_RD;
                end
            end
            ST_SCT_B:
            begin
                row_raddr  = RAW'(ent_col_q);
                state_next = ST_SCT_BW;
            end
            ST_SCT_BW:
            begin
                csr_we     = 1'b1;
                csr_wcol   = COL_W'(ent_row_q);
                row_we     = 1'b1;
                row_waddr  = RAW'(ent_col_q);
                idx_next   = idx_reg + EW'(1);
                state_next = ST_SCT_RD;
            end
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            ri_reg      <= '0;
            total_reg   <= '0;
            acc_reg     <= '0;
            entries_reg <= '0;
            unf_reg     <= '0;
            built_reg   <= 1'b0;
            op_reg      <= OP_LOAD;
            sts_reg     <= STS_OK;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ri_reg      <= ri_next;
            total_reg   <= total_next;
            acc_reg     <= acc_next;
            entries_reg <= entries_next;
            unf_reg     <= unf_next;
            built_reg   <= built_next;
            op_reg      <= op_next;
            sts_reg     <= sts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        col_reg  <= col_next;
    end

endmodule

[rtl/core/coo_to_csr_converter.sv]
// Sparse matrix builder: takes COO entries and turns them into CSR form.
// Input channel in_ch carries one command item: load an entry, finish the
// build, read a row pointer or read an element. Output channel out_ch returns
// exactly one result item per command (status, data, column, unfolded count).
// Registers (mode, rows, columns, declared count) are to be written over APB
// only while the block is idle; the block itself does not enforce this.
// A load or a rejected command goes straight to its result; a read first
// waits for its memory read.
// Finish walks the entry store and row memory through one port each: it
// checks the entries, clears the row memory over all MAX_ROWS rows, counts
// entries per row, builds the row pointers by prefix sum and scatters the
// entries into CSR order, mirrored ones included in symmetric mode.
// One command is in work at a time; in_ch.ready is high only when idle.
// A finished result sits in the output register; the next command is taken
// while it waits, and the engine holds its next result until the register
// frees. Reset empties the store, clears the counts and built flag and
// returns the registers to their defaults.
module coo_to_csr_converter
    import coo_pkg::*;
#(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096,
    parameter int VALUE_WIDTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    coo_in_if.sink            in_ch,
    coo_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t      cfg;
    in_item_t  item;
    out_item_t res;
    out_item_t out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      res_valid, res_ready;

    assign item.operation    = in_ch.operation;
    assign item.entry_row    = in_ch.entry_row;
    assign item.entry_column = in_ch.entry_column;
    assign item.entry_value  = in_ch.entry_value;
    assign item.read_index   = in_ch.read_index;

    coo_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    coo_engine #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_reg.status;
    assign out_ch.data_word      = out_reg.data_word;
    assign out_ch.column_out     = out_reg.column_out;
    assign out_ch.unfolded_count = out_reg.unfolded_count;

endmodule

[rtl/core/coo_chk.sv]
module coo_chk
    import coo_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [STS_W-1:0]  status,
    input logic [DATA_W-1:0] data_word,
    input logic [COL_W-1:0]  column_out
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("took a new item right after accepting one");

    a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> data_word == '0 && column_out == '0)
        else $error("failed item carries data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(data_word))
        else $error("stalled result changed");

endmodule

bind coo_to_csr_converter coo_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .data_word  (out_ch.data_word),
    .column_out (out_ch.column_out)
);
